// ===== hdl/lcas_pkg.sv =====
// ----------------------------------------------------------------------------
// Life automaton step package
// Shared widths, reset values, register indexes and types.
// ----------------------------------------------------------------------------
package lcas_pkg;

    localparam int LCAS_MAX_WIDTH = 1024;

    localparam int GRID_WIDTH_W  = 11;
    localparam int GRID_HEIGHT_W = 12;
    localparam int ROW_W         = 12;
    localparam int COL_OUT_W     = 10;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 12;

    localparam logic [GRID_WIDTH_W-1:0]  GRID_WIDTH_RESET  = GRID_WIDTH_W'(64);
    localparam logic [GRID_HEIGHT_W-1:0] GRID_HEIGHT_RESET = GRID_HEIGHT_W'(64);

    localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = CFG_INDEX_W'(1);

    // per-cell position flags from the raster scanner
    typedef struct packed {
        logic emit;        // window centered on an interior cell
        logic frame_last;  // last interior cell of the grid
    } scan_flags_t;

endpackage

// ===== hdl/life_cellular_automaton_step.sv =====
// ----------------------------------------------------------------------------
// Life cellular automaton step
// One generation of B3/S23 over a raster cell stream, interior cells out.
// ----------------------------------------------------------------------------
//  Channel  Dir  Transaction
//  s_       in   one current-generation cell, raster order
//  m_       out  next state of one interior cell, with row/column
//  cfg_     in   register write: 0 grid_width, 1 grid_height
//
//  One cell per clock sustained while the output does not stall. A cell
//  enters the input stage, where the line-buffer RAM read completes, then the
//  window/rule result lands in the output register. Synchronous active-low
//  reset clears counters, window and valids; the line buffers are not
//  cleared. A stalled output holds the input stage, which holds s_tready low;
//  border cells pass through without a result.
// ----------------------------------------------------------------------------
module life_cellular_automaton_step
    import lcas_pkg::*;
#(
    parameter int MAX_WIDTH = LCAS_MAX_WIDTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // config write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // cell input
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [0] cell_alive, [7:1] zero
    // result output
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [23:0]            m_tdata,   // [0] next_alive, [12:1] cell_row,
                                              // [22:13] cell_col, [23] zero
    output logic                   m_tlast    // frame_last
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic                cfg_we;
    logic                cfg_restart;
    logic                s_accept;
    logic [ROW_W-1:0]    scan_row;
    logic [CW-1:0]       scan_col;
    scan_flags_t         scan_flags;

    logic                s1_valid_reg, s1_valid_next;
    logic                s1_x_reg;
    logic [ROW_W-1:0]    s1_row_reg;
    logic [CW-1:0]       s1_col_reg;
    scan_flags_t         s1_flags_reg;
    logic                s1_adv;
    logic                out_free;
    logic [1:0]          buf_rd;     // [0] upper row, [1] middle row
    logic                rule_alive;
    logic [31:0]         col_m1;

    logic                m_valid_reg, m_valid_next;
    logic                next_alive_reg;
    logic [ROW_W-1:0]    cell_row_reg;
    logic [COL_OUT_W-1:0] cell_col_reg;
    logic                frame_last_reg;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // only the two size registers restart the grid
    assign cfg_restart = cfg_we &&
                         (cfg_index == REG_GRID_WIDTH || cfg_index == REG_GRID_HEIGHT);

    assign out_free = !m_valid_reg || m_tready;
    assign s1_adv   = s1_valid_reg && (out_free || !s1_flags_reg.emit);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign s_accept = s_tvalid && s_tready;

    lcas_scan #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (s_accept),
        .row       (scan_row),
        .col       (scan_col),
        .flags     (scan_flags)
    );

    // both line buffers share one RAM: read at accept, write when stage 1 moves
    lcas_ram #(
        .WIDTH (2),
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .aclk    (aclk),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data ({s1_x_reg, buf_rd[1]}),
        .rd_en   (s_accept),
        .rd_addr (scan_col),
        .rd_data (buf_rd)
    );

    lcas_window u_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .clear      (cfg_restart),
        .step       (s1_adv),
        .col_bits   ({s1_x_reg, buf_rd}),
        .next_alive (rule_alive)
    );

    // input stage
    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_x_reg     <= s_tdata[0];
            s1_row_reg   <= scan_row;
            s1_col_reg   <= scan_col;
            s1_flags_reg <= scan_flags;
        end
    end

    // output register
    assign col_m1 = 32'(s1_col_reg) - 32'd1;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s1_adv && s1_flags_reg.emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv && s1_flags_reg.emit) begin
            next_alive_reg <= rule_alive;
            cell_row_reg   <= s1_row_reg - ROW_W'(1);
            cell_col_reg   <= col_m1[COL_OUT_W-1:0];
            frame_last_reg <= s1_flags_reg.frame_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, cell_col_reg, cell_row_reg, next_alive_reg};
    assign m_tlast  = frame_last_reg;

endmodule

// ===== hdl/lcas_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module lcas_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/lcas_scan.sv =====
// ----------------------------------------------------------------------------
// Raster scanner
// Grid size registers, row/column counters and interior-cell flags.
// ----------------------------------------------------------------------------
module lcas_scan
    import lcas_pkg::*;
#(
    parameter int MAX_WIDTH = LCAS_MAX_WIDTH
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [CFG_INDEX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    input  logic                         step,
    output logic [ROW_W-1:0]             row,
    output logic [$clog2(MAX_WIDTH)-1:0] col,
    output scan_flags_t                  flags
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int CWP = CW + 1;

    logic [GRID_WIDTH_W-1:0]  grid_width_reg;
    logic [GRID_HEIGHT_W-1:0] grid_height_reg;
    logic [ROW_W-1:0]         row_reg, row_next;
    logic [CW-1:0]            col_reg, col_next;
    logic [CWP-1:0]           w_eff;
    logic [CW-1:0]            w_last;
    logic [GRID_HEIGHT_W-1:0] h_eff;
    logic [ROW_W-1:0]         h_last;
    logic                     restart;

    // out-of-range sizes clamp to the legal range
    always_comb begin
        if (32'(grid_width_reg) < 32'd3) begin
            w_eff = CWP'(3);
        end else if (32'(grid_width_reg) > 32'(MAX_WIDTH)) begin
            w_eff = CWP'(MAX_WIDTH);
        end else begin
            w_eff = CWP'(grid_width_reg);
        end
        w_last = CW'(w_eff - CWP'(1));
        h_eff  = (grid_height_reg < GRID_HEIGHT_W'(3)) ? GRID_HEIGHT_W'(3) : grid_height_reg;
        h_last = ROW_W'(h_eff - GRID_HEIGHT_W'(1));
    end

    assign restart = cfg_we && (cfg_index == REG_GRID_WIDTH || cfg_index == REG_GRID_HEIGHT);

    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        if (restart) begin
            row_next = '0;
            col_next = '0;
        end else if (step) begin
            if (col_reg == w_last) begin
                col_next = '0;
                row_next = (row_reg == h_last) ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg  <= GRID_WIDTH_RESET;
            grid_height_reg <= GRID_HEIGHT_RESET;
            row_reg         <= '0;
            col_reg         <= '0;
        end else begin
            if (cfg_we && cfg_index == REG_GRID_WIDTH) begin
                grid_width_reg <= cfg_data[GRID_WIDTH_W-1:0];
            end
            if (cfg_we && cfg_index == REG_GRID_HEIGHT) begin
                grid_height_reg <= cfg_data[GRID_HEIGHT_W-1:0];
            end
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    assign row              = row_reg;
    assign col              = col_reg;
    assign flags.emit       = (row_reg >= ROW_W'(2)) && (32'(col_reg) >= 32'd2);
    assign flags.frame_last = (row_reg == h_last) && (col_reg == w_last);

endmodule

// ===== hdl/lcas_window.sv =====
// ----------------------------------------------------------------------------
// Neighborhood window and B3/S23 rule
// Holds the two previous columns of the 3x3 window and evaluates the center.
// ----------------------------------------------------------------------------
module lcas_window
    import lcas_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       clear,
    input  logic       step,
    input  logic [2:0] col_bits,    // bit0 row r-2, bit1 row r-1, bit2 row r
    output logic       next_alive
);

    logic [5:0] window_reg;         // [5:3] column c-2, [2:0] column c-1
    logic       center;
    logic [3:0] total;
    logic [3:0] nbrs;

    assign center = window_reg[1];
    assign total  = 4'(window_reg[0]) + 4'(window_reg[1]) + 4'(window_reg[2])
                  + 4'(window_reg[3]) + 4'(window_reg[4]) + 4'(window_reg[5])
                  + 4'(col_bits[0])   + 4'(col_bits[1])   + 4'(col_bits[2]);
    assign nbrs   = total - 4'(center);

    assign next_alive = (nbrs == 4'd3) || (center && nbrs == 4'd2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= '0;
        end else if (clear) begin
            window_reg <= '0;
        end else if (step) begin
            window_reg <= {window_reg[2:0], col_bits};
        end
    end

endmodule
